// File: hw/rtl/boris_velocity_push_top_defines.svh
// ----------------------------------------------------------------------------
// Boris velocity push: assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef BORIS_VELOCITY_PUSH_TOP_DEFINES_SVH
`define BORIS_VELOCITY_PUSH_TOP_DEFINES_SVH

// checked only out of reset
`define BVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define BVP_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/bvp_pkg.sv
// ----------------------------------------------------------------------------
// Boris velocity push: package
// Widths, beat types and saturating fixed point helpers.
// ----------------------------------------------------------------------------
package bvp_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned FracBitsDef = 16;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic        [DataWidth-1:0] udata_t;

  localparam data_t SMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t SMin = {1'b1, {(DataWidth-1){1'b0}}};

  typedef struct packed {
    data_t vel_x;
    data_t vel_y;
    data_t vel_z;
    data_t e_x;
    data_t e_y;
    data_t e_z;
    data_t b_x;
    data_t b_y;
    data_t b_z;
    data_t particle_charge;
  } in_beat_t;

  typedef struct packed {
    data_t new_vel_x;
    data_t new_vel_y;
    data_t new_vel_z;
  } out_beat_t;

  function automatic udata_t mag(input data_t a);
    udata_t m;
    m = a[DataWidth-1] ? udata_t'(-a) : udata_t'(a);
    return m;
  endfunction

  function automatic data_t sat_add(input data_t a, input data_t b);
    logic [DataWidth:0] s;
    data_t r;
    s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
    if (s[DataWidth] != s[DataWidth-1]) begin
      r = s[DataWidth] ? SMin : SMax;
    end else begin
      r = data_t'(s[DataWidth-1:0]);
    end
    return r;
  endfunction

  // negated operand clamps to SMax when it is the most negative value
  function automatic data_t sat_sub(input data_t a, input data_t b);
    data_t nb;
    nb = (b == SMin) ? SMax : -b;
    return sat_add(a, nb);
  endfunction

endpackage

// File: hw/rtl/boris_velocity_push_top.sv
// ----------------------------------------------------------------------------
// Boris velocity push: top level
// Half electric kick, magnetic rotation scaled by 1/(1+|r|^2), second kick.
//
//   port group   dir   flow control      beat
//   in_*         in    valid / stall     bvp_pkg::in_beat_t
//   out_*        out   valid / stall     bvp_pkg::out_beat_t
//   cfg_*        in    valid / ready     half_dt_over_mass
//
// One beat per cycle while in_stall_o is low; the pipeline depth is set by the
// one-bit-per-stage divider after the multiplier stages.
// Reset clears all valid bits; half_dt_over_mass resets to 1.0.
// A stalled output fills one skid entry, then in_stall_o rises and the whole
// pipeline holds. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`include "boris_velocity_push_top_defines.svh"

module boris_velocity_push_top #(
  parameter int unsigned FracBits = bvp_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bvp_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bvp_pkg::out_beat_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  bvp_pkg::udata_t    cfg_data_i
);

  localparam int unsigned W    = bvp_pkg::DataWidth;
  localparam int unsigned Last = W + 15;
  localparam int unsigned KDly = W + 11;
  localparam bvp_pkg::udata_t HdmRst = bvp_pkg::udata_t'(1) << FracBits;
  localparam int CrA [3] = '{0, 0, 1};
  localparam int CrB [3] = '{1, 2, 2};

  logic              en;
  logic              skid_full;
  logic [Last:0]     vld_q;
  bvp_pkg::udata_t   hdm_q;
  bvp_pkg::in_beat_t in_q;

  bvp_pkg::data_t vel [3], ef [3], bf [3];
  bvp_pkg::data_t coef;
  bvp_pkg::data_t ed_q [2][3];
  bvp_pkg::data_t bd_q [2][3];
  bvp_pkg::data_t vd_q [4][3];
  bvp_pkg::data_t kv [3], rv [3];
  bvp_pkg::data_t kd_q [KDly][3];
  bvp_pkg::data_t ud_q [5][3];
  bvp_pkg::data_t rd_q [2][3];
  bvp_pkg::data_t sq [3], cr [3];
  bvp_pkg::data_t mat [9];
  bvp_pkg::data_t det;
  bvp_pkg::data_t dd_q [4];
  bvp_pkg::data_t prod [9];
  bvp_pkg::data_t s1_q [3], p2_q [3], s_q [3];
  bvp_pkg::data_t quo [3];
  bvp_pkg::out_beat_t push_data;

  assign cfg_ready_o = 1'b1;
  assign en          = !skid_full;
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdm_q <= HdmRst;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        hdm_q <= cfg_data_i;
      end
      if (en) begin
        vld_q <= {vld_q[Last-1:0], in_valid_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  assign vel = '{in_q.vel_x, in_q.vel_y, in_q.vel_z};
  assign ef  = '{in_q.e_x, in_q.e_y, in_q.e_z};
  assign bf  = '{in_q.b_x, in_q.b_y, in_q.b_z};

  bvp_mul #(.FracBits(FracBits)) u_coef (
    .clk_i (clk_i),
    .en_i  (en),
    .neg_i (in_q.particle_charge[W-1]),
    .a_i   (bvp_pkg::mag(in_q.particle_charge)),
    .b_i   (hdm_q),
    .p_o   (coef)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ed_q[0][c] <= ef[c];
        ed_q[1][c] <= ed_q[0][c];
        bd_q[0][c] <= bf[c];
        bd_q[1][c] <= bd_q[0][c];
        vd_q[0][c] <= vel[c];
        for (int i = 1; i < 4; i++) begin
          vd_q[i][c] <= vd_q[i-1][c];
        end
        kd_q[0][c] <= kv[c];
        for (int i = 1; i < KDly; i++) begin
          kd_q[i][c] <= kd_q[i-1][c];
        end
        ud_q[0][c] <= bvp_pkg::sat_add(vd_q[3][c], kv[c]);
        for (int i = 1; i < 5; i++) begin
          ud_q[i][c] <= ud_q[i-1][c];
        end
        rd_q[0][c] <= rv[c];
        rd_q[1][c] <= rd_q[0][c];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_kick
    bvp_mul #(.FracBits(FracBits)) u_k (
      .clk_i (clk_i),
      .en_i  (en),
      .neg_i (coef[W-1] ^ ed_q[1][c][W-1]),
      .a_i   (bvp_pkg::mag(coef)),
      .b_i   (bvp_pkg::mag(ed_q[1][c])),
      .p_o   (kv[c])
    );
    bvp_mul #(.FracBits(FracBits)) u_r (
      .clk_i (clk_i),
      .en_i  (en),
      .neg_i (coef[W-1] ^ bd_q[1][c][W-1]),
      .a_i   (bvp_pkg::mag(coef)),
      .b_i   (bvp_pkg::mag(bd_q[1][c])),
      .p_o   (rv[c])
    );
    bvp_mul #(.FracBits(FracBits)) u_sq (
      .clk_i (clk_i),
      .en_i  (en),
      .neg_i (1'b0),
      .a_i   (bvp_pkg::mag(rv[c])),
      .b_i   (bvp_pkg::mag(rv[c])),
      .p_o   (sq[c])
    );
    bvp_mul #(.FracBits(FracBits)) u_cr (
      .clk_i (clk_i),
      .en_i  (en),
      .neg_i (rv[CrA[c]][W-1] ^ rv[CrB[c]][W-1]),
      .a_i   (bvp_pkg::mag(rv[CrA[c]])),
      .b_i   (bvp_pkg::mag(rv[CrB[c]])),
      .p_o   (cr[c])
    );
  end

  bvp_rot #(.FracBits(FracBits)) u_rot (
    .clk_i (clk_i),
    .en_i  (en),
    .r_i   (rd_q[1]),
    .sq_i  (sq),
    .cr_i  (cr),
    .mat_o (mat),
    .det_o (det)
  );

  for (genvar row = 0; row < 3; row++) begin : g_row
    for (genvar col = 0; col < 3; col++) begin : g_col
      bvp_mul #(.FracBits(FracBits)) u_m (
        .clk_i (clk_i),
        .en_i  (en),
        .neg_i (mat[row*3+col][W-1] ^ ud_q[4][col][W-1]),
        .a_i   (bvp_pkg::mag(mat[row*3+col])),
        .b_i   (bvp_pkg::mag(ud_q[4][col])),
        .p_o   (prod[row*3+col])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q[0] <= det;
      for (int i = 1; i < 4; i++) begin
        dd_q[i] <= dd_q[i-1];
      end
      for (int r = 0; r < 3; r++) begin
        s1_q[r] <= bvp_pkg::sat_add(prod[r*3], prod[r*3+1]);
        p2_q[r] <= prod[r*3+2];
        s_q[r]  <= bvp_pkg::sat_add(s1_q[r], p2_q[r]);
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    bvp_div #(.FracBits(FracBits)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s_q[c]),
      .det_i (dd_q[3]),
      .q_o   (quo[c])
    );
  end

  always_comb begin
    push_data.new_vel_x = bvp_pkg::sat_add(quo[0], kd_q[KDly-1][0]);
    push_data.new_vel_y = bvp_pkg::sat_add(quo[1], kd_q[KDly-1][1]);
    push_data.new_vel_z = bvp_pkg::sat_add(quo[2], kd_q[KDly-1][2]);
  end

  bvp_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (vld_q[Last]),
    .push_data_i  (push_data),
    .full_o       (skid_full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  `BVP_ASSERT(a_accept_enters, (in_valid_i && !in_stall_o) |=> vld_q[0], "accepted beat lost")
  `BVP_ASSERT(a_hold_on_stall, in_stall_o |=> $stable(vld_q), "pipeline moved while held")
  `BVP_ASSERT(a_cfg_write, (cfg_valid_i && cfg_ready_o) |=> (hdm_q == $past(cfg_data_i)), "cfg write missed")

endmodule

// File: hw/rtl/bvp_mul.sv
// ----------------------------------------------------------------------------
// Boris velocity push: fixed point multiplier
// Sign-magnitude product, round to nearest (ties away), saturate. 2 stages.
// ----------------------------------------------------------------------------
module bvp_mul #(
  parameter int unsigned FracBits = bvp_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           neg_i,
  input  bvp_pkg::udata_t a_i,
  input  bvp_pkg::udata_t b_i,
  output bvp_pkg::data_t  p_o
);

  localparam int unsigned W  = bvp_pkg::DataWidth;
  localparam int unsigned PW = 2 * W;
  localparam logic [PW:0] Rnd = (PW+1)'(1) << (FracBits - 1);

  logic [PW-1:0]  prod_q;
  logic           neg_q;
  bvp_pkg::data_t p_q;
  logic [PW:0]    sum;
  logic [PW:0]    shr;
  logic           big;
  bvp_pkg::data_t res;

  always_comb begin
    sum = {1'b0, prod_q} + Rnd;
    shr = sum >> FracBits;
    big = |shr[PW:W-1];
    if (big) begin
      res = neg_q ? bvp_pkg::SMin : bvp_pkg::SMax;
    end else if (neg_q) begin
      res = bvp_pkg::data_t'(W'(0) - shr[W-1:0]);
    end else begin
      res = bvp_pkg::data_t'(shr[W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(a_i) * PW'(b_i);
      neg_q  <= neg_i;
      p_q    <= res;
    end
  end

  assign p_o = p_q;

endmodule

// File: hw/rtl/bvp_rot.sv
// ----------------------------------------------------------------------------
// Boris velocity push: rotation matrix
// Builds det = 1+|r|^2 and the nine matrix terms over three stages.
// ----------------------------------------------------------------------------
module bvp_rot #(
  parameter int unsigned FracBits = bvp_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  bvp_pkg::data_t r_i   [3],
  input  bvp_pkg::data_t sq_i  [3],
  input  bvp_pkg::data_t cr_i  [3],
  output bvp_pkg::data_t mat_o [9],
  output bvp_pkg::data_t det_o
);

  localparam int unsigned W = bvp_pkg::DataWidth;
  localparam bvp_pkg::data_t One =
    bvp_pkg::data_t'({{(W-1){1'b0}}, 1'b1} << FracBits);

  // stage 1
  bvp_pkg::data_t det1_q, myy1_q, mzz1_q;
  bvp_pkg::data_t off1_q [6];
  bvp_pkg::data_t sq1_q  [3];
  // stage 2
  bvp_pkg::data_t det2_q, mxx2_q, myy2_q, mzz2_q;
  bvp_pkg::data_t off2_q [6];
  bvp_pkg::data_t ry2_2_q, rz2_2_q;
  // stage 3
  bvp_pkg::data_t det_q;
  bvp_pkg::data_t mat_q  [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det1_q    <= bvp_pkg::sat_add(One, sq_i[0]);
      myy1_q    <= bvp_pkg::sat_add(One, sq_i[1]);
      mzz1_q    <= bvp_pkg::sat_add(One, sq_i[2]);
      off1_q[0] <= bvp_pkg::sat_add(cr_i[0], r_i[2]);
      off1_q[1] <= bvp_pkg::sat_sub(cr_i[1], r_i[1]);
      off1_q[2] <= bvp_pkg::sat_sub(cr_i[0], r_i[2]);
      off1_q[3] <= bvp_pkg::sat_add(cr_i[2], r_i[0]);
      off1_q[4] <= bvp_pkg::sat_add(cr_i[1], r_i[1]);
      off1_q[5] <= bvp_pkg::sat_sub(cr_i[2], r_i[0]);
      for (int i = 0; i < 3; i++) begin
        sq1_q[i] <= sq_i[i];
      end

      det2_q  <= bvp_pkg::sat_add(det1_q, sq1_q[1]);
      mxx2_q  <= bvp_pkg::sat_sub(det1_q, sq1_q[1]);
      myy2_q  <= bvp_pkg::sat_sub(myy1_q, sq1_q[0]);
      mzz2_q  <= bvp_pkg::sat_sub(mzz1_q, sq1_q[0]);
      for (int i = 0; i < 6; i++) begin
        off2_q[i] <= bvp_pkg::sat_add(off1_q[i], off1_q[i]);
      end
      ry2_2_q <= sq1_q[1];
      rz2_2_q <= sq1_q[2];

      det_q    <= bvp_pkg::sat_add(det2_q, rz2_2_q);
      mat_q[0] <= bvp_pkg::sat_sub(mxx2_q, rz2_2_q);
      mat_q[1] <= off2_q[0];
      mat_q[2] <= off2_q[1];
      mat_q[3] <= off2_q[2];
      mat_q[4] <= bvp_pkg::sat_sub(myy2_q, rz2_2_q);
      mat_q[5] <= off2_q[3];
      mat_q[6] <= off2_q[4];
      mat_q[7] <= off2_q[5];
      mat_q[8] <= bvp_pkg::sat_sub(mzz2_q, ry2_2_q);
    end
  end

  assign mat_o = mat_q;
  assign det_o = det_q;

endmodule

// File: hw/rtl/bvp_div.sv
// ----------------------------------------------------------------------------
// Boris velocity push: pipelined divider
// num / det rounded to nearest, one restoring quotient bit per stage.
// det is at least 1.0, so the quotient fits in DataWidth bits; a set top bit saturates.
// ----------------------------------------------------------------------------
module bvp_div #(
  parameter int unsigned FracBits = bvp_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  bvp_pkg::data_t num_i,
  input  bvp_pkg::data_t det_i,
  output bvp_pkg::data_t q_o
);

  localparam int unsigned W  = bvp_pkg::DataWidth;
  localparam int unsigned Dw = W + FracBits;

  logic [W-1:0]    rem_q [W+1];
  logic [W-1:0]    lo_q  [W+1];
  logic [W-1:0]    quo_q [W+1];
  bvp_pkg::udata_t d_q   [W+1];
  logic            neg_q [W+1];
  bvp_pkg::data_t  q_q;

  bvp_pkg::udata_t n;
  logic [Dw-1:0]   dvd;

  always_comb begin
    n   = bvp_pkg::mag(num_i);
    dvd = {n, {FracBits{1'b0}}} + Dw'(bvp_pkg::udata_t'(det_i) >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= W'(dvd[Dw-1:W]);
      lo_q[0]  <= dvd[W-1:0];
      quo_q[0] <= '0;
      d_q[0]   <= bvp_pkg::udata_t'(det_i);
      neg_q[0] <= num_i[W-1];
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    always_comb begin
      trial = {rem_q[j], lo_q[j][W-1]};
      diff  = trial - {1'b0, d_q[j]};
      ge    = (trial >= {1'b0, d_q[j]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? diff[W-1:0] : trial[W-1:0];
        lo_q[j+1]  <= lo_q[j] << 1;
        quo_q[j+1] <= {quo_q[j][W-2:0], ge};
        d_q[j+1]   <= d_q[j];
        neg_q[j+1] <= neg_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (quo_q[W][W-1]) begin
        q_q <= neg_q[W] ? bvp_pkg::SMin : bvp_pkg::SMax;
      end else if (neg_q[W]) begin
        q_q <= bvp_pkg::data_t'(W'(0) - quo_q[W]);
      end else begin
        q_q <= bvp_pkg::data_t'(quo_q[W]);
      end
    end
  end

  assign q_o = q_q;

endmodule

// File: hw/rtl/bvp_skid.sv
// ----------------------------------------------------------------------------
// Boris velocity push: output buffer
// Output register plus one skid entry; full stops the pipeline.
// ----------------------------------------------------------------------------
`include "boris_velocity_push_top_defines.svh"

module bvp_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  input  bvp_pkg::out_beat_t push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bvp_pkg::out_beat_t out_data_o
);

  logic               out_v_q, out_v_d;
  logic               skid_v_q, skid_v_d;
  bvp_pkg::out_beat_t out_q, skid_q;
  logic               push, out_free, load_out, load_skid, sel_skid;

  always_comb begin
    push      = push_valid_i && !skid_v_q;
    out_free  = !out_v_q || !out_stall_i;
    out_v_d   = out_v_q;
    skid_v_d  = skid_v_q;
    load_out  = 1'b0;
    load_skid = 1'b0;
    sel_skid  = 1'b0;
    if (out_free) begin
      if (skid_v_q) begin
        load_out = 1'b1;
        sel_skid = 1'b1;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        load_out = push;
        out_v_d  = push;
      end
    end else if (push) begin
      load_skid = 1'b1;
      skid_v_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= sel_skid ? skid_q : push_data_i;
    end
    if (load_skid) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `BVP_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid beat without output beat")
  `BVP_ASSERT(a_skid_drain, (skid_v_q && !out_stall_i) |=> !skid_v_q, "skid did not drain")
  `BVP_ASSERT_ALL(a_rst_quiet, !rst_ni |=> !out_valid_o, "output valid right after reset")

endmodule
